// ===== hw/rtl/seg_pkg.sv =====
// Package for the signed Elias gamma encoder.
// Holds the item type passed from the front part through the queue to the back part.
// No dependencies.
package seg_pkg;

    localparam int BYTE_W   = 8;
    localparam int CODE_W   = 32;   // code number u, at most 2^31
    localparam int LEN_W    = 6;    // significant bit count n, 1..32
    localparam int VALUE_W  = 31;

    typedef struct packed {
        logic                flush;
        logic [CODE_W-1:0]   code_num;
        logic [LEN_W-1:0]    code_len;
    } seg_item_t;

endpackage

// ===== hw/rtl/signed_elias_gamma_encoder.sv =====
// Top level of the signed Elias gamma encoder.
// Instantiates seg_front, seg_queue and seg_back; depends on seg_pkg.
//
// Usage:
//   Input channel item_valid/item_ready carries value (31-bit signed) and flush.
//   A value item maps v to u (2|v| for negative v, 2v+1 otherwise) and appends the
//   Elias gamma code of u (n-1 zeros, then the n bits of u) to the bit stream.
//   A flush item pads the partial byte with zeros and sends it out.
//   Output channel byte_valid/byte_ready carries code_byte, packed first bit in
//   bit 7, and last_byte, set on the final byte caused by an item. Items that
//   complete no byte produce nothing.
// The first byte of an item, when nothing is ahead of it, passes the front register,
//   the queue, the back part's shift register and the output register.
// Throughput: the back part sends one byte per cycle while the receiver takes it; an
//   item that completes no byte only updates the pending bits, and the next item can
//   load as the final byte of an item goes out. An item produces at most 8 bytes. The
//   front accepts one item per cycle while the queue of QUEUE_DEPTH items has room.
// Reset clears the pending bits and empties the pipeline. When the receiver
//   stalls, the output byte holds, the back part waits, and the queue and front
//   register fill before item_ready drops.
module signed_elias_gamma_encoder
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic signed [seg_pkg::VALUE_W-1:0] value,
    input  logic                               flush,
    output logic                               byte_valid,
    input  logic                               byte_ready,
    output logic [seg_pkg::BYTE_W-1:0]         code_byte,
    output logic                               last_byte
);

    logic               fq_valid;
    logic               fq_ready;
    seg_pkg::seg_item_t fq_item;
    logic               qb_valid;
    logic               qb_ready;
    seg_pkg::seg_item_t qb_item;

    seg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .value      (value),
        .flush      (flush),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_item     (fq_item)
    );

    seg_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    seg_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (qb_valid),
        .q_ready    (qb_ready),
        .q_item     (qb_item),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .code_byte  (code_byte),
        .last_byte  (last_byte)
    );

endmodule

// ===== hw/rtl/seg_front.sv =====
// Front part of the signed Elias gamma encoder: accepts items, maps the signed value
// to its code number and counts its significant bits. Depends on seg_pkg.
module seg_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic signed [seg_pkg::VALUE_W-1:0] value,
    input  logic                               flush,
    output logic                               q_valid,
    input  logic                               q_ready,
    output seg_pkg::seg_item_t                 q_item
);

    logic                            front_valid_reg;
    logic                            front_valid_next;
    seg_pkg::seg_item_t              item_reg;
    seg_pkg::seg_item_t              item_next;
    logic [seg_pkg::VALUE_W-1:0]     mag;
    logic [seg_pkg::CODE_W-1:0]      code_num;
    logic [seg_pkg::LEN_W-1:0]       code_len;

    assign item_ready = !front_valid_reg || q_ready;
    assign q_valid    = front_valid_reg;
    assign q_item     = item_reg;

    // Negative values map to twice the magnitude, others to twice plus one.
    always_comb
    begin
        mag = seg_pkg::VALUE_W'(-value);
        if (value[seg_pkg::VALUE_W-1])
        begin
            code_num = {mag, 1'b0};
        end
        else
        begin
            code_num = {value, 1'b1};
        end
    end

    always_comb
    begin
        code_len = '0;
        for (int i = 0; i < seg_pkg::CODE_W; i++)
        begin
            if (code_num[i])
            begin
                code_len = seg_pkg::LEN_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        front_valid_next = front_valid_reg;
        item_next        = item_reg;
        if (item_valid && item_ready)
        begin
            front_valid_next   = 1'b1;
            item_next.flush    = flush;
            item_next.code_num = code_num;
            item_next.code_len = code_len;
        end
        else if (q_ready)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== hw/rtl/seg_queue.sv =====
// Short queue between the front and back parts of the signed Elias gamma encoder.
// Depends on seg_pkg for the item type.
module seg_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  seg_pkg::seg_item_t wr_item,
    output logic               rd_valid,
    input  logic               rd_ready,
    output seg_pkg::seg_item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    seg_pkg::seg_item_t  entries [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                push;
    logic                pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entries[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= wr_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_W'(DEPTH)) && !pop |=> count_reg == CNT_W'(DEPTH))
        else $error("full queue changed without a pop");

    a_empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) && !push |=> count_reg == '0)
        else $error("empty queue changed without a push");

endmodule

// ===== hw/rtl/seg_back.sv =====
// Back part of the signed Elias gamma encoder: merges each code with the pending bits,
// emits complete bytes one per cycle unless stalled, keeps the partial byte. Depends on seg_pkg.
module seg_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  seg_pkg::seg_item_t                q_item,
    output logic                              byte_valid,
    input  logic                              byte_ready,
    output logic [seg_pkg::BYTE_W-1:0]        code_byte,
    output logic                              last_byte
);

    localparam int BW   = seg_pkg::BYTE_W;
    localparam int SR_W = 72;           // 7 pending bits plus a 63-bit code fit
    localparam int SH_W = 7;
    localparam int NB_W = 4;
    localparam int RM_W = 3;

    logic                busy_reg;
    logic                busy_next;
    logic [SR_W-1:0]     sr_reg;
    logic [SR_W-1:0]     sr_next;
    logic [NB_W-1:0]     nbytes_reg;
    logic [NB_W-1:0]     nbytes_next;
    logic [RM_W-1:0]     rem_reg;
    logic [RM_W-1:0]     rem_next;
    logic [BW-1:0]       pend_reg;
    logic [BW-1:0]       pend_next;
    logic [RM_W-1:0]     cnt_reg;
    logic [RM_W-1:0]     cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [BW-1:0]       code_byte_reg;
    logic [BW-1:0]       code_byte_next;
    logic                last_byte_reg;
    logic                last_byte_next;

    logic                slot_free;
    logic                emit;
    logic                finishing;
    logic                take;
    logic [BW-1:0]       cur_pend;
    logic [RM_W-1:0]     cur_cnt;
    logic [SR_W-1:0]     sr_ld;
    logic [NB_W-1:0]     nb_ld;
    logic [RM_W-1:0]     rem_ld;
    logic [SH_W-1:0]     shift_amt;
    logic [SH_W-1:0]     total;
    logic [SH_W-1:0]     len2;

    // Pending bits are kept left-aligned in a byte; only the top cnt bits are valid.
    function automatic logic [BW-1:0] top_mask(input logic [RM_W-1:0] cnt);
        top_mask = ~({BW{1'b1}} >> cnt);
    endfunction

    assign slot_free  = !out_valid_reg || byte_ready;
    assign emit       = busy_reg && slot_free;
    assign finishing  = emit && (nbytes_reg == NB_W'(1));
    assign q_ready    = !busy_reg || finishing;
    assign take       = q_valid && q_ready;
    assign byte_valid = out_valid_reg;
    assign code_byte  = code_byte_reg;
    assign last_byte  = last_byte_reg;

    // The bits left over by the item in flight are forwarded so the next item can load
    // in the same cycle as the final byte goes out.
    always_comb
    begin
        if (finishing)
        begin
            cur_pend = sr_reg[SR_W-BW-1 -: BW] & top_mask(rem_reg);
            cur_cnt  = rem_reg;
        end
        else
        begin
            cur_pend = pend_reg;
            cur_cnt  = cnt_reg;
        end
    end

    // The code is n-1 zeros then u, i.e. u right-justified in a 2n-1 bit field placed
    // just after the pending bits.
    always_comb
    begin
        len2      = {1'b0, q_item.code_len} << 1;
        shift_amt = SH_W'(SR_W + 1) - {{(SH_W-RM_W){1'b0}}, cur_cnt} - len2;
        total     = {{(SH_W-RM_W){1'b0}}, cur_cnt} + len2 - SH_W'(1);
        if (q_item.flush)
        begin
            sr_ld  = {cur_pend, {(SR_W-BW){1'b0}}};
            nb_ld  = {{(NB_W-1){1'b0}}, (cur_cnt != '0)};
            rem_ld = '0;
        end
        else
        begin
            sr_ld  = {cur_pend, {(SR_W-BW){1'b0}}}
                   | ({{(SR_W-seg_pkg::CODE_W){1'b0}}, q_item.code_num} << shift_amt);
            nb_ld  = total[SH_W-1 -: NB_W];
            rem_ld = total[RM_W-1:0];
        end
    end

    always_comb
    begin
        busy_next   = busy_reg;
        sr_next     = sr_reg;
        nbytes_next = nbytes_reg;
        rem_next    = rem_reg;
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        if (emit)
        begin
            sr_next     = sr_reg << BW;
            nbytes_next = nbytes_reg - 1'b1;
            if (finishing)
            begin
                busy_next = 1'b0;
                pend_next = cur_pend;
                cnt_next  = cur_cnt;
            end
        end
        if (take)
        begin
            if (nb_ld == '0)
            begin
                busy_next = 1'b0;
                pend_next = sr_ld[SR_W-1 -: BW] & top_mask(rem_ld);
                cnt_next  = rem_ld;
            end
            else
            begin
                busy_next   = 1'b1;
                sr_next     = sr_ld;
                nbytes_next = nb_ld;
                rem_next    = rem_ld;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        code_byte_next = code_byte_reg;
        last_byte_next = last_byte_reg;
        if (slot_free)
        begin
            out_valid_next = emit;
            code_byte_next = sr_reg[SR_W-1 -: BW];
            last_byte_next = (nbytes_reg == NB_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            nbytes_reg    <= '0;
            rem_reg       <= '0;
            pend_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            nbytes_reg    <= nbytes_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg         <= sr_next;
        code_byte_reg  <= code_byte_next;
        last_byte_reg  <= last_byte_next;
    end

    a_busy_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (nbytes_reg != '0) && (nbytes_reg <= NB_W'(8)))
        else $error("busy with no bytes left or too many bytes");

    a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg & ~top_mask(cnt_reg)) == '0)
        else $error("pending byte has stray bits below its count");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !slot_free |=> busy_reg && $stable(nbytes_reg) && $stable(sr_reg))
        else $error("byte sequence advanced while the output was stalled");

endmodule
